[sv/usb_host_in_channel_event_handler_macros.svh]
// Assertion helpers for the handler file, which checks its own logic.
// Both sample on the rising edge of clock and stay quiet while reset is high.
`ifndef USB_HOST_IN_CHANNEL_EVENT_HANDLER_MACROS_SVH
`define USB_HOST_IN_CHANNEL_EVENT_HANDLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UHICE_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uhice check failed");

// Consequent must hold in the cycle after the antecedent.
`define UHICE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uhice check failed");

`endif

[sv/uhice_pkg.sv]
package uhice_pkg;

   localparam int CH_W    = 4;
   localparam int EV_W    = 10;
   localparam int XLEN_W  = 19;
   localparam int ERR_W   = 8;
   localparam int RETRY_W = 4;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 56;

   // Bit positions inside the pending event word.
   localparam int EV_XFRC  = 0;
   localparam int EV_CHH   = 1;
   localparam int EV_AHB   = 2;
   localparam int EV_STALL = 3;
   localparam int EV_NAK   = 4;
   localparam int EV_ACK   = 5;
   localparam int EV_TXERR = 6;
   localparam int EV_BBERR = 7;
   localparam int EV_FRMOR = 8;
   localparam int EV_DTERR = 9;

   // Configuration register indexes.
   localparam logic CSR_DMA_MODE    = 1'b0;
   localparam logic CSR_RETRY_LIMIT = 1'b1;

   localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = 4'd3;

   typedef enum logic [1:0] {
      EP_CTRL = 2'd0,
      EP_ISOC = 2'd1,
      EP_BULK = 2'd2,
      EP_INTR = 2'd3
   } ept_type;

   typedef enum logic [2:0] {
      CS_IDLE   = 3'd0,
      CS_XFRC   = 3'd1,
      CS_NAK    = 3'd2,
      CS_STALL  = 3'd3,
      CS_XACT   = 3'd4,
      CS_BABBLE = 3'd5,
      CS_TGL    = 3'd6
   } cond_type;

   typedef enum logic [2:0] {
      URB_IDLE    = 3'd0,
      URB_SUCCESS = 3'd1,
      URB_NRDY    = 3'd2,
      URB_ERR     = 3'd3,
      URB_HALTED  = 3'd4
   } urb_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_UNMASK = 2'd1,
      ACT_MASK   = 2'd2
   } act_type;

   typedef struct packed {
      logic                 dma_mode;
      logic [RETRY_W-1:0]   retry_limit;
   } cfg_type;

   typedef struct packed {
      cond_type             cond;
      urb_type              urb;
      logic [ERR_W-1:0]     err;
      logic                 tog;
      logic [XLEN_W-1:0]    cnt;
   } chan_state_type;

   typedef struct packed {
      logic [CH_W-1:0]      channel;
      logic [EV_W-1:0]      event_flags;
      ept_type              endpoint_type;
      logic [XLEN_W-1:0]    transfer_length;
      logic [XLEN_W-1:0]    remaining_size;
   } evt_type;

   typedef struct packed {
      logic [EV_W-1:0]      clear_flags;
      logic                 halt_request;
      act_type              halt_irq_action;
      logic                 reenable_channel;
      logic                 set_odd_frame;
      logic                 notify_urb;
   } action_type;

endpackage

[sv/uhice_state.sv]
module uhice_state #(
   parameter int NUM_CHANNELS = 16,
   parameter int CH_IDX_W     = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CH_IDX_W-1:0]      rd_idx,
   output uhice_pkg::chan_state_type rd_data,
   input  logic                     wr_en,
   input  logic [CH_IDX_W-1:0]      wr_idx,
   input  uhice_pkg::chan_state_type wr_data
);
   import uhice_pkg::*;

   chan_state_type state_ff [NUM_CHANNELS];

   // Indexes past the last channel read back as the reset value.
   always_comb begin
      rd_data = '0;
      if (32'(rd_idx) < NUM_CHANNELS) begin
         rd_data = state_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            state_ff[i] <= '0;
         end
      end else if (wr_en) begin
         state_ff[wr_idx] <= wr_data;
      end
   end

endmodule

[sv/uhice_eval.sv]
module uhice_eval (
   input  uhice_pkg::cfg_type        cfg,
   input  uhice_pkg::evt_type        evt,
   input  uhice_pkg::chan_state_type st_old,
   output uhice_pkg::chan_state_type st_new,
   output uhice_pkg::action_type     act_out
);
   import uhice_pkg::*;

   logic [EV_W-1:0]  clr;
   logic [EV_W-1:0]  pend;
   logic [EV_W-1:0]  ev;
   logic [ERR_W-1:0] err_sat;

   function automatic logic [ERR_W-1:0] sat_inc(input logic [ERR_W-1:0] v);
      logic [ERR_W-1:0] r;
      r = (v == '1) ? v : v + ERR_W'(1);
      return r;
   endfunction

   always_comb begin
      ev      = evt.event_flags;
      st_new  = st_old;
      clr     = '0;
      act_out = '0;
      err_sat = '0;

      // Error and handshake conditions come first.
      if (ev[EV_AHB]) begin
         clr[EV_AHB]             = 1'b1;
         act_out.halt_irq_action = ACT_UNMASK;
      end else if (ev[EV_BBERR]) begin
         clr[EV_BBERR]           = 1'b1;
         st_new.cond             = CS_BABBLE;
         act_out.halt_irq_action = ACT_UNMASK;
         act_out.halt_request    = 1'b1;
      end else if (ev[EV_ACK]) begin
         clr[EV_ACK] = 1'b1;
      end else if (ev[EV_STALL]) begin
         act_out.halt_irq_action = ACT_UNMASK;
         st_new.cond             = CS_STALL;
         clr[EV_NAK]             = 1'b1;
         clr[EV_STALL]           = 1'b1;
         act_out.halt_request    = 1'b1;
      end else if (ev[EV_DTERR]) begin
         act_out.halt_irq_action = ACT_UNMASK;
         act_out.halt_request    = 1'b1;
         clr[EV_NAK]             = 1'b1;
         clr[EV_DTERR]           = 1'b1;
         st_new.cond             = CS_TGL;
      end

      // The second chain only sees what the first one left pending.
      pend = ev & ~clr;
      if (pend[EV_FRMOR]) begin
         act_out.halt_irq_action = ACT_UNMASK;
         act_out.halt_request    = 1'b1;
         clr[EV_FRMOR]           = 1'b1;
      end else if (pend[EV_XFRC]) begin
         if (cfg.dma_mode) begin
            st_new.cnt = evt.transfer_length - evt.remaining_size;
         end
         st_new.cond  = CS_XFRC;
         st_new.err   = '0;
         clr[EV_XFRC] = 1'b1;
         case (evt.endpoint_type)
            EP_CTRL, EP_BULK: begin
               act_out.halt_irq_action = ACT_UNMASK;
               act_out.halt_request    = 1'b1;
               clr[EV_NAK]             = 1'b1;
            end
            EP_INTR: begin
               act_out.set_odd_frame = 1'b1;
               st_new.urb            = URB_SUCCESS;
               act_out.notify_urb    = 1'b1;
            end
            default: begin
               st_new.urb         = URB_SUCCESS;
               act_out.notify_urb = 1'b1;
            end
         endcase
         // Isochronous completion leaves the toggle as it was; every other type flips it.
         if (evt.endpoint_type != EP_ISOC) begin
            st_new.tog = ~st_new.tog;
         end
      end else if (pend[EV_CHH]) begin
         act_out.halt_irq_action = ACT_MASK;
         err_sat                 = sat_inc(st_new.err);
         case (st_new.cond)
            CS_XFRC:  st_new.urb = URB_SUCCESS;
            CS_STALL: st_new.urb = URB_HALTED;
            CS_XACT, CS_TGL: begin
               if (err_sat > ERR_W'(cfg.retry_limit)) begin
                  st_new.err = '0;
                  st_new.urb = URB_ERR;
               end else begin
                  st_new.err = err_sat;
                  st_new.urb = URB_NRDY;
               end
               act_out.reenable_channel = 1'b1;
            end
            CS_NAK: begin
               st_new.urb               = URB_NRDY;
               act_out.reenable_channel = 1'b1;
            end
            CS_BABBLE: begin
               st_new.err = err_sat;
               st_new.urb = URB_ERR;
            end
            default: ;
         endcase
         clr[EV_CHH]        = 1'b1;
         act_out.notify_urb = 1'b1;
      end else if (pend[EV_TXERR]) begin
         act_out.halt_irq_action = ACT_UNMASK;
         st_new.err              = sat_inc(st_new.err);
         st_new.cond             = CS_XACT;
         act_out.halt_request    = 1'b1;
         clr[EV_TXERR]           = 1'b1;
      end else if (pend[EV_NAK]) begin
         case (evt.endpoint_type)
            EP_INTR: begin
               // The channel halts but the condition is left alone.
               st_new.err              = '0;
               act_out.halt_irq_action = ACT_UNMASK;
               act_out.halt_request    = 1'b1;
            end
            EP_CTRL, EP_BULK: begin
               st_new.err = '0;
               if (!cfg.dma_mode) begin
                  st_new.cond             = CS_NAK;
                  act_out.halt_irq_action = ACT_UNMASK;
                  act_out.halt_request    = 1'b1;
               end
            end
            default: ;
         endcase
         clr[EV_NAK] = 1'b1;
      end

      act_out.clear_flags = clr;
   end

endmodule

[sv/usb_host_in_channel_event_handler.sv]
// IN host-channel event handler. Each item on the req_ stream is one pending
// interrupt word of one channel; each produces exactly one rsp_ item with the
// flags to clear, the halt, mask and re-enable requests, the URB notification
// and the channel's updated status, toggle, byte count and error count. The
// block takes an item every cycle while the output side is not stalled: an
// item is held in the input register, is evaluated against its channel's
// state in one pass, and its result lands in the output register, from which
// it is presented on the rsp_ stream. The per-channel state lives in
// flip-flops that reset clears at once, so no clearing pass is needed, and
// a read-modify-write of that state in the evaluation stage is what lets
// events of the same channel follow each other back to back. Channel numbers
// at or above NUM_CHANNELS give an all-zero result and touch no state.
// Configuration (csr_index 0: DMA mode, 1: retry limit) is to be written by
// the user only while no item is in flight; the block does not enforce it.
module usb_host_in_channel_event_handler #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // channel[3:0], event_flags[13:4], endpoint_type[15:14],
   // transfer_length[34:16], remaining_size[53:35], zero fill [55:54]
   input  logic [uhice_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // clear_flags[9:0], halt_request[10], halt_irq_action[12:11],
   // reenable_channel[13], set_odd_frame[14], notify_urb[15],
   // urb_result[18:16], channel_status[21:19], received_count[40:22],
   // data_toggle[41], error_total[49:42], zero fill [55:50]
   output logic [uhice_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [uhice_pkg::RETRY_W-1:0]     csr_wdata
);
   import uhice_pkg::*;

`include "usb_host_in_channel_event_handler_macros.svh"

   localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Configuration registers.
   cfg_type cfg_ff, cfg_in;

   // Input register stage.
   evt_type in_ff, in_in;
   logic    in_valid_ff, in_valid_in;

   // Output register stage.
   action_type     rsp_act_ff, rsp_act_in;
   chan_state_type rsp_st_ff, rsp_st_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic           advance;
   logic           in_range;
   logic           st_wr_en;
   chan_state_type st_old, st_new;
   action_type     act_new;

   // The evaluation stage moves whenever the output register is empty or
   // being drained; the input register refills in the same cycle.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign in_range   = {1'b0, in_ff.channel} < (CH_W + 1)'(NUM_CHANNELS);
   assign st_wr_en   = in_valid_ff && advance && in_range;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DMA_MODE:    cfg_in.dma_mode    = csr_wdata[0];
            CSR_RETRY_LIMIT: cfg_in.retry_limit = csr_wdata;
            default: ;
         endcase
      end
   end

   // Unpack the request stream into its fields.
   always_comb begin
      in_in.channel         = req_tdata[3:0];
      in_in.event_flags     = req_tdata[13:4];
      in_in.endpoint_type   = ept_type'(req_tdata[15:14]);
      in_in.transfer_length = req_tdata[34:16];
      in_in.remaining_size  = req_tdata[53:35];
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_st_in    = rsp_st_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
         // Out-of-range channels report nothing but zeros.
         rsp_act_in   = in_range ? act_new : '0;
         rsp_st_in    = in_range ? st_new : '0;
      end
   end

   uhice_state #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .CH_IDX_W     (CH_IDX_W)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (in_ff.channel[CH_IDX_W-1:0]),
      .rd_data (st_old),
      .wr_en   (st_wr_en),
      .wr_idx  (in_ff.channel[CH_IDX_W-1:0]),
      .wr_data (st_new)
   );

   uhice_eval u_eval (
      .cfg     (cfg_ff),
      .evt     (in_ff),
      .st_old  (st_old),
      .st_new  (st_new),
      .act_out (act_new)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dma_mode    <= 1'b0;
         cfg_ff.retry_limit <= RETRY_LIMIT_RESET;
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_ff <= in_in;
      end
      rsp_act_ff <= rsp_act_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0,
                        rsp_st_ff.err,
                        rsp_st_ff.tog,
                        rsp_st_ff.cnt,
                        rsp_st_ff.cond,
                        rsp_st_ff.urb,
                        rsp_act_ff.notify_urb,
                        rsp_act_ff.set_odd_frame,
                        rsp_act_ff.reenable_channel,
                        rsp_act_ff.halt_irq_action,
                        rsp_act_ff.halt_request,
                        rsp_act_ff.clear_flags};

   // A channel past the configured count must never update the state store.
   `UHICE_ASSERT_SAME(a_no_write_out_of_range, in_valid_ff && !in_range, !st_wr_en)
   // Re-enabling only follows a halted event, which always masks the interrupt.
   `UHICE_ASSERT_SAME(a_reenable_masks, rsp_valid_ff && rsp_act_ff.reenable_channel,
                      rsp_act_ff.halt_irq_action == ACT_MASK)
   // An accepted item is held in the input register on the next cycle.
   `UHICE_ASSERT_NEXT(a_accept_loads, req_tvalid && req_tready, in_valid_ff)

endmodule

[dv/tb_usb_host_in_channel_event_handler.sv]
module tb_usb_host_in_channel_event_handler;
   timeunit 1ns;
   timeprecision 1ps;

   import uhice_pkg::*;

   localparam int CHANNELS    = 16;
   localparam int PHASE_ITEMS = 400;
   localparam int STORM_ITEMS = 260;
   localparam int CYCLE_LIMIT = 200000;

   // Bits that may ride along with a transaction error during an error storm.
   // None of them can zero the error count, so the count climbs to saturation.
   localparam logic [EV_W-1:0] STORM_NOISE = EV_W'((1 << EV_AHB) | (1 << EV_STALL) |
      (1 << EV_NAK) | (1 << EV_ACK) | (1 << EV_BBERR) | (1 << EV_DTERR));

   // One result item as it sits on rsp_tdata, last field in the lowest bits.
   typedef struct packed {
      logic [5:0]        fill;
      logic [ERR_W-1:0]  error_total;
      logic              data_toggle;
      logic [XLEN_W-1:0] received_count;
      logic [2:0]        channel_status;
      logic [2:0]        urb_result;
      logic              notify_urb;
      logic              set_odd_frame;
      logic              reenable_channel;
      logic [1:0]        halt_irq_action;
      logic              halt_request;
      logic [EV_W-1:0]   clear_flags;
   } outcome_type;

   // Per-channel model of the handler plus the queue of outcomes it predicts.
   class event_outcome_board;
      cond_type          cond_of[CHANNELS];
      urb_type           urb_of[CHANNELS];
      logic [ERR_W-1:0]  errors_of[CHANNELS];
      logic              toggle_of[CHANNELS];
      logic [XLEN_W-1:0] count_of[CHANNELS];
      logic              dma_on;
      logic [RETRY_W-1:0] retry;
      outcome_type       expected_outcomes[$];
      int                mismatches;

      function void clear_state();
         foreach (cond_of[i]) begin
            cond_of[i]   = CS_IDLE;
            urb_of[i]    = URB_IDLE;
            errors_of[i] = '0;
            toggle_of[i] = 1'b0;
            count_of[i]  = '0;
         end
         dma_on      = 1'b0;
         retry       = RETRY_LIMIT_RESET;
         mismatches  = 0;
      endfunction

      function void set_config(logic idx, logic [RETRY_W-1:0] value);
         if (idx == CSR_DMA_MODE) begin
            dma_on = value[0];
         end else begin
            retry = value;
         end
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction

      function void bump_errors(int ch);
         if (errors_of[ch] != '1) begin
            errors_of[ch] = errors_of[ch] + 1'b1;
         end
      endfunction

      function void note_event(evt_type ev);
         int              ch;
         logic [EV_W-1:0] f;
         logic [EV_W-1:0] pend;
         logic [EV_W-1:0] clr;
         logic            halt;
         logic            reen;
         logic            odd;
         logic            notify;
         act_type         act;
         outcome_type     o;
         ch     = ev.channel;
         f      = ev.event_flags;
         clr    = '0;
         halt   = 1'b0;
         reen   = 1'b0;
         odd    = 1'b0;
         notify = 1'b0;
         act    = ACT_NONE;

         // First chain: bus errors and handshake outcomes, by priority.
         if (f[EV_AHB]) begin
            clr[EV_AHB] = 1'b1;
            act = ACT_UNMASK;
         end else if (f[EV_BBERR]) begin
            clr[EV_BBERR] = 1'b1;
            cond_of[ch] = CS_BABBLE;
            act = ACT_UNMASK;
            halt = 1'b1;
         end else if (f[EV_ACK]) begin
            clr[EV_ACK] = 1'b1;
         end else if (f[EV_STALL]) begin
            act = ACT_UNMASK;
            cond_of[ch] = CS_STALL;
            clr[EV_NAK] = 1'b1;
            clr[EV_STALL] = 1'b1;
            halt = 1'b1;
         end else if (f[EV_DTERR]) begin
            act = ACT_UNMASK;
            halt = 1'b1;
            clr[EV_NAK] = 1'b1;
            clr[EV_DTERR] = 1'b1;
            cond_of[ch] = CS_TGL;
         end

         // Second chain only sees what the first one left pending.
         pend = f & ~clr;
         if (pend[EV_FRMOR]) begin
            act = ACT_UNMASK;
            halt = 1'b1;
            clr[EV_FRMOR] = 1'b1;
         end else if (pend[EV_XFRC]) begin
            if (dma_on) begin
               count_of[ch] = ev.transfer_length - ev.remaining_size;
            end
            cond_of[ch] = CS_XFRC;
            errors_of[ch] = '0;
            clr[EV_XFRC] = 1'b1;
            case (ev.endpoint_type)
               EP_CTRL, EP_BULK: begin
                  act = ACT_UNMASK;
                  halt = 1'b1;
                  clr[EV_NAK] = 1'b1;
               end
               EP_INTR: begin
                  odd = 1'b1;
                  urb_of[ch] = URB_SUCCESS;
                  notify = 1'b1;
               end
               default: begin
                  urb_of[ch] = URB_SUCCESS;
                  toggle_of[ch] = ~toggle_of[ch];
                  notify = 1'b1;
               end
            endcase
            toggle_of[ch] = ~toggle_of[ch];
         end else if (pend[EV_CHH]) begin
            act = ACT_MASK;
            case (cond_of[ch])
               CS_XFRC: urb_of[ch] = URB_SUCCESS;
               CS_STALL: urb_of[ch] = URB_HALTED;
               CS_XACT, CS_TGL: begin
                  bump_errors(ch);
                  if (errors_of[ch] > retry) begin
                     errors_of[ch] = '0;
                     urb_of[ch] = URB_ERR;
                  end else begin
                     urb_of[ch] = URB_NRDY;
                  end
                  reen = 1'b1;
               end
               CS_NAK: begin
                  urb_of[ch] = URB_NRDY;
                  reen = 1'b1;
               end
               CS_BABBLE: begin
                  bump_errors(ch);
                  urb_of[ch] = URB_ERR;
               end
               default: ;
            endcase
            clr[EV_CHH] = 1'b1;
            notify = 1'b1;
         end else if (pend[EV_TXERR]) begin
            act = ACT_UNMASK;
            bump_errors(ch);
            cond_of[ch] = CS_XACT;
            halt = 1'b1;
            clr[EV_TXERR] = 1'b1;
         end else if (pend[EV_NAK]) begin
            if (ev.endpoint_type == EP_INTR) begin
               errors_of[ch] = '0;
               act = ACT_UNMASK;
               halt = 1'b1;
            end else if (ev.endpoint_type == EP_CTRL || ev.endpoint_type == EP_BULK) begin
               errors_of[ch] = '0;
               if (!dma_on) begin
                  cond_of[ch] = CS_NAK;
                  act = ACT_UNMASK;
                  halt = 1'b1;
               end
            end
            clr[EV_NAK] = 1'b1;
         end

         o                  = '0;
         o.clear_flags      = clr;
         o.halt_request     = halt;
         o.halt_irq_action  = act;
         o.reenable_channel = reen;
         o.set_odd_frame    = odd;
         o.notify_urb       = notify;
         o.urb_result       = urb_of[ch];
         o.channel_status   = cond_of[ch];
         o.received_count   = count_of[ch];
         o.data_toggle      = toggle_of[ch];
         o.error_total      = errors_of[ch];
         expected_outcomes.push_back(o);
      endfunction

      function void compare_field(string name, logic [XLEN_W-1:0] want,
                                  logic [XLEN_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_outcome(logic [RSP_TDATA_W-1:0] word);
         outcome_type got;
         outcome_type want;
         got = outcome_type'(word);
         if (expected_outcomes.size() == 0) begin
            $display("%0t: result item with nothing expected, expected none, actual %h",
                     $time, word);
            mismatches++;
            return;
         end
         want = expected_outcomes.pop_front();
         compare_field("clear_flags", want.clear_flags, got.clear_flags);
         compare_field("halt_request", want.halt_request, got.halt_request);
         compare_field("halt_irq_action", want.halt_irq_action, got.halt_irq_action);
         compare_field("reenable_channel", want.reenable_channel, got.reenable_channel);
         compare_field("set_odd_frame", want.set_odd_frame, got.set_odd_frame);
         compare_field("notify_urb", want.notify_urb, got.notify_urb);
         compare_field("urb_result", want.urb_result, got.urb_result);
         compare_field("channel_status", want.channel_status, got.channel_status);
         compare_field("received_count", want.received_count, got.received_count);
         compare_field("data_toggle", want.data_toggle, got.data_toggle);
         compare_field("error_total", want.error_total, got.error_total);
         compare_field("zero fill", want.fill, got.fill);
      endfunction
   endclass

   // Every input of the block starts at a known value; reset is high from time zero.
   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic [REQ_TDATA_W-1:0]   req_tdata   = '0;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic                     csr_we      = 1'b0;
   logic                     csr_index   = 1'b0;
   logic [RETRY_W-1:0]       csr_wdata   = '0;

   // Percentages of cycles in which each side holds back.
   int send_idle_pct = 14;
   int recv_idle_pct = 46;
   int cycles        = 0;

   event_outcome_board board;

   usb_host_in_channel_event_handler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // The receiver decides once per cycle, on the falling edge, whether it stalls.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Results are taken at the rising edge at which valid and ready are both high.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_outcome(rsp_tdata);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("usb_host_in_channel_event_handler verification failed");
         $finish;
      end
   end

   // Presents one item, idling first at the sender's rate, and hands it to the
   // predictor once the block has taken it. Valid stays high between back to back
   // items, so it only ever gets one assignment per falling edge.
   task automatic send_event(input evt_type ev);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, ev.remaining_size, ev.transfer_length, ev.endpoint_type,
                     ev.event_flags, ev.channel};
      do @(posedge clock); while (!req_tready);
      board.note_event(ev);
   endtask

   task automatic send_fields(input logic [CH_W-1:0] ch, input logic [EV_W-1:0] flags,
                              input ept_type ept, input logic [XLEN_W-1:0] xlen,
                              input logic [XLEN_W-1:0] rem);
      evt_type ev;
      ev.channel         = ch;
      ev.event_flags     = flags;
      ev.endpoint_type   = ept;
      ev.transfer_length = xlen;
      ev.remaining_size  = rem;
      send_event(ev);
   endtask

   // Drops valid and waits until every outstanding result has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [RETRY_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      board.set_config(idx, value);
   endtask

   // Configuration only changes with the block idle, so every phase starts by
   // draining what is still in flight.
   task automatic configure(input logic dma, input logic [RETRY_W-1:0] limit,
                            input int send_pct, input int recv_pct);
      drain();
      write_csr(CSR_DMA_MODE, {3'b000, dma});
      write_csr(CSR_RETRY_LIMIT, limit);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Lengths lean toward the extremes so that the DMA byte count sees zero,
   // the full range and the wrap when more remains than was requested.
   function automatic logic [XLEN_W-1:0] pick_length();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return XLEN_W'($urandom);
      endcase
   endfunction

   function automatic evt_type random_event(input logic [CH_W-1:0] ch,
                                            input logic [EV_W-1:0] flags);
      evt_type ev;
      ev.channel         = ch;
      ev.event_flags     = flags;
      ev.endpoint_type   = ept_type'($urandom_range(3));
      ev.transfer_length = pick_length();
      ev.remaining_size  = pick_length();
      return ev;
   endfunction

   // The event that normally precedes a halted interrupt, with occasional noise.
   function automatic logic [EV_W-1:0] pick_condition();
      logic [EV_W-1:0] f;
      f = '0;
      case ($urandom_range(8))
         0: begin
            f[EV_XFRC] = 1'b1;
            f[EV_ACK]  = 1'($urandom_range(1));
         end
         1: f[EV_NAK] = 1'b1;
         2: f[EV_TXERR] = 1'b1;
         3: begin
            f[EV_STALL] = 1'b1;
            f[EV_NAK]   = 1'($urandom_range(1));
         end
         4: f[EV_BBERR] = 1'b1;
         5: begin
            f[EV_DTERR] = 1'b1;
            f[EV_NAK]   = 1'($urandom_range(1));
         end
         6: f[EV_FRMOR] = 1'b1;
         7: f[EV_AHB] = 1'b1;
         default: f[EV_XFRC] = 1'b1;
      endcase
      if ($urandom_range(7) == 0) begin
         f[$urandom_range(EV_W-1)] = 1'b1;
      end
      return f;
   endfunction

   // Mostly condition-then-halted pairs on one channel, which is how the
   // hardware reports a finished transaction; the rest is single events and
   // arbitrary flag words.
   task automatic run_random(input int total);
      int              n;
      logic [CH_W-1:0] ch;
      logic [EV_W-1:0] f;
      n = 0;
      while (n < total) begin
         ch = CH_W'($urandom);
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
               send_event(random_event(ch, pick_condition()));
               f = '0;
               f[EV_CHH] = 1'b1;
               if ($urandom_range(5) == 0) begin
                  f[EV_ACK] = 1'b1;
               end
               send_event(random_event(ch, f));
               n += 2;
            end
            6, 7: begin
               send_event(random_event(ch, EV_W'($urandom)));
               n++;
            end
            default: begin
               f = '0;
               f[$urandom_range(EV_W-1)] = 1'b1;
               send_event(random_event(ch, f));
               n++;
            end
         endcase
      end
   endtask

   // A long run of transaction errors on one channel with nothing that clears
   // the count, so the error total reaches its ceiling and must stay there.
   task automatic run_storm();
      logic [CH_W-1:0] ch;
      logic [EV_W-1:0] f;
      ch = CH_W'($urandom);
      repeat (STORM_ITEMS) begin
         f = EV_W'($urandom) & STORM_NOISE;
         f[EV_TXERR] = 1'b1;
         send_event(random_event(ch, f));
      end
   endtask

   // Directed opening with the reset configuration, then a few DMA cases.
   task automatic run_directed();
      logic [EV_W-1:0] f;
      send_fields(4'd0, '0, EP_CTRL, '0, '0);
      f = '0; f[EV_XFRC] = 1'b1; f[EV_ACK] = 1'b1;
      send_fields(4'd0, f, EP_CTRL, '1, '0);
      f = '0; f[EV_CHH] = 1'b1;
      send_fields(4'd0, f, EP_CTRL, '0, '0);
      // Halted while the channel's last condition is still idle.
      send_fields(4'd1, f, EP_BULK, '0, '0);
      f = '0; f[EV_STALL] = 1'b1; f[EV_NAK] = 1'b1;
      send_fields(4'd1, f, EP_BULK, '0, '0);
      f = '0; f[EV_CHH] = 1'b1;
      send_fields(4'd1, f, EP_BULK, '0, '0);
      // Every flag at once: the AHB error wins the first chain, overrun the second.
      send_fields(4'd2, '1, EP_CTRL, '1, '1);
      f = '0; f[EV_BBERR] = 1'b1;
      send_fields(4'd2, f, EP_CTRL, '0, '0);
      f = '0; f[EV_CHH] = 1'b1;
      send_fields(4'd2, f, EP_CTRL, '0, '0);
      f = '0; f[EV_DTERR] = 1'b1; f[EV_NAK] = 1'b1;
      send_fields(4'd3, f, EP_INTR, '0, '0);
      f = '0; f[EV_CHH] = 1'b1;
      send_fields(4'd3, f, EP_INTR, '0, '0);
      f = '0; f[EV_TXERR] = 1'b1;
      send_fields(4'd3, f, EP_INTR, '0, '0);
      f = '0; f[EV_CHH] = 1'b1;
      send_fields(4'd3, f, EP_INTR, '0, '0);
      // NAK on an interrupt endpoint halts without changing the condition,
      // on isochronous it is only acknowledged.
      f = '0; f[EV_NAK] = 1'b1;
      send_fields(4'd4, f, EP_INTR, '0, '0);
      send_fields(4'd4, f, EP_ISOC, '0, '0);
      send_fields(4'd4, f, EP_BULK, '0, '0);
      f = '0; f[EV_CHH] = 1'b1;
      send_fields(4'd4, f, EP_BULK, '0, '0);
      // Isochronous completion leaves the toggle as it was; interrupt sets odd frame.
      f = '0; f[EV_XFRC] = 1'b1;
      send_fields(4'd5, f, EP_ISOC, '1, '0);
      send_fields(4'd5, f, EP_INTR, '0, '0);
      f = '0; f[EV_FRMOR] = 1'b1; f[EV_XFRC] = 1'b1;
      send_fields(4'd6, f, EP_INTR, '0, '0);

      configure(1'b1, RETRY_LIMIT_RESET, 14, 46);
      // More remaining than requested: the DMA byte count wraps.
      f = '0; f[EV_XFRC] = 1'b1;
      send_fields(4'd8, f, EP_BULK, '0, '1);
      f = '0; f[EV_NAK] = 1'b1;
      send_fields(4'd8, f, EP_CTRL, '0, '0);
      f = '0; f[EV_XFRC] = 1'b1; f[EV_ACK] = 1'b1;
      send_fields(4'd15, f, EP_CTRL, '1, 19'd1);
   endtask

   initial begin
      board = new;
      board.clear_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      // Sender idles lightly, receiver stalls often.
      configure(1'b1, 4'd0, 14, 46);
      run_random(PHASE_ITEMS);
      // Roles swapped: the sender holds back, the receiver rarely stalls.
      configure(1'b0, 4'd15, 46, 14);
      run_storm();
      run_random(PHASE_ITEMS);
      configure(1'b1, 4'd15, 46, 14);
      run_random(PHASE_ITEMS);
      // Full rate on both sides.
      configure(1'b0, 4'd1, 0, 0);
      run_random(PHASE_ITEMS);
      configure(1'b1, 4'd7, 0, 0);
      run_random(PHASE_ITEMS);

      drain();
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("usb_host_in_channel_event_handler verification clean");
      end else begin
         $display("usb_host_in_channel_event_handler verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/uhice_pkg.sv
sv/uhice_state.sv
sv/uhice_eval.sv
sv/usb_host_in_channel_event_handler.sv
dv/tb_usb_host_in_channel_event_handler.sv
